// ----- rtl/core/ttas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttas_pkg
// Shared types, field layout and codes of the tile animation sequencer.
// ----------------------------------------------------------------------------
package ttas_pkg;

   // item codes carried in req_tuser
   typedef enum logic [1:0] {
      FN_TICK   = 2'd0,
      FN_DESC   = 2'd1,
      FN_STEP   = 2'd2,
      FN_BITMAP = 2'd3
   } func_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_STEP
   } seq_state_type;

   // field widths
   localparam int FUNC_W  = 2;
   localparam int CHAN_W  = 3;
   localparam int SIDX_W  = 4;
   localparam int DUR_W   = 7;
   localparam int FRM_W   = 3;
   localparam int TIDX_W  = 4;
   localparam int BMP_W   = 12;
   localparam int CNT_W   = 5;
   localparam int SLOT_W  = 12;
   localparam int TIMER_W = 8;

   // request tdata layout, lowest bit first
   localparam int CHAN_LSB  = 0;
   localparam int SIDX_LSB  = CHAN_LSB + CHAN_W;
   localparam int DUR_LSB   = SIDX_LSB + SIDX_W;
   localparam int FRM_LSB   = DUR_LSB + DUR_W;
   localparam int TIDX_LSB  = FRM_LSB + FRM_W;
   localparam int BMP_LSB   = TIDX_LSB + TIDX_W;
   localparam int SCNT_LSB  = BMP_LSB + BMP_W;
   localparam int FIRST_LSB = SCNT_LSB + CNT_W;
   localparam int TCNT_LSB  = FIRST_LSB + SLOT_W;
   localparam int REQ_W     = 56;

   // response tdata layout
   localparam int RSP_W = SLOT_W + BMP_W;

   // change handed from the sequencer to the emitter
   typedef struct packed {
      logic              start;
      logic [SLOT_W-1:0] first_tile;
      logic [CNT_W-1:0]  count;
   } emit_cmd_type;

endpackage

// ----- rtl/core/ttas_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttas_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/ttas_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttas_emit
// Bitmap table and the tile pair walk: one bitmap read per cycle unless the
// output stalls, RAM data stage and output register with backpressure.
// ----------------------------------------------------------------------------
module ttas_emit
   import ttas_pkg::*;
#(
   parameter int BM_DEPTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  emit_cmd_type                                  cmd,
   input  logic [(BM_DEPTH > 1 ? $clog2(BM_DEPTH) : 1)-1:0] cmd_base,
   input  logic                                          bm_we,
   input  logic [(BM_DEPTH > 1 ? $clog2(BM_DEPTH) : 1)-1:0] bm_waddr,
   input  logic [BMP_W-1:0]                              bm_wdata,
   output logic                                          busy,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [RSP_W-1:0]                              rsp_tdata,
   output logic                                          rsp_tlast
);

   localparam int BM_AW = BM_DEPTH > 1 ? $clog2(BM_DEPTH) : 1;

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [BM_AW-1:0]  base_ff, base_in;
   logic [SLOT_W-1:0] first_ff, first_in;
   logic              a_vld_ff, a_vld_in;
   logic [SLOT_W-1:0] a_slot_ff, a_slot_in;
   logic              a_last_ff, a_last_in;
   logic              o_vld_ff, o_vld_in;
   logic [SLOT_W-1:0] o_slot_ff, o_slot_in;
   logic [BMP_W-1:0]  o_bmp_ff, o_bmp_in;
   logic              o_last_ff, o_last_in;
   logic [BMP_W-1:0]  bm_rdata;
   logic              out_free, advance, issue;
   logic [CNT_W-1:0]  idx_nxt;

   ttas_ram #(
      .WIDTH (BMP_W),
      .DEPTH (BM_DEPTH)
   ) u_bitmap_ram (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .re    (issue),
      .raddr (base_ff + BM_AW'(idx_ff)),
      .rdata (bm_rdata)
   );

   always_comb begin
      out_free  = !o_vld_ff || rsp_tready;
      advance   = a_vld_ff && out_free;
      issue     = busy_ff && (!a_vld_ff || out_free);
      idx_nxt   = idx_ff + CNT_W'(1);

      busy_in   = busy_ff;
      idx_in    = idx_ff;
      num_in    = num_ff;
      base_in   = base_ff;
      first_in  = first_ff;
      a_vld_in  = a_vld_ff;
      a_slot_in = a_slot_ff;
      a_last_in = a_last_ff;
      o_vld_in  = o_vld_ff;
      o_slot_in = o_slot_ff;
      o_bmp_in  = o_bmp_ff;
      o_last_in = o_last_ff;

      if (cmd.start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         num_in   = cmd.count;
         base_in  = cmd_base;
         first_in = cmd.first_tile;
      end

      // issue the next bitmap read; its slot and last mark travel beside it
      if (issue) begin
         idx_in    = idx_nxt;
         busy_in   = (idx_nxt != num_ff);
         a_vld_in  = 1'b1;
         a_slot_in = first_ff + SLOT_W'(idx_ff);
         a_last_in = (idx_nxt == num_ff);
      end else if (advance) begin
         a_vld_in = 1'b0;
      end

      if (advance) begin
         o_vld_in  = 1'b1;
         o_slot_in = a_slot_ff;
         o_bmp_in  = bm_rdata;
         o_last_in = a_last_ff;
      end else if (rsp_tready) begin
         o_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         a_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         a_vld_ff <= a_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      num_ff    <= num_in;
      base_ff   <= base_in;
      first_ff  <= first_in;
      a_slot_ff <= a_slot_in;
      a_last_ff <= a_last_in;
      o_slot_ff <= o_slot_in;
      o_bmp_ff  <= o_bmp_in;
      o_last_ff <= o_last_in;
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {o_bmp_ff, o_slot_ff};
   assign rsp_tlast  = o_last_ff;

endmodule

// ----- rtl/core/ttas_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttas_seq
// Item decode, table writes and the per-channel timer and step update done
// as read, modify and write back over the channel and sequence RAMs.
// ----------------------------------------------------------------------------
module ttas_seq
   import ttas_pkg::*;
#(
   parameter int CHANNELS = 8,
   parameter int STEPS    = 16,
   parameter int FRAMES   = 8,
   parameter int TILES    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_W-1:0]         req_tdata,
   input  logic [FUNC_W-1:0]        req_tuser,
   input  logic                     emit_busy,
   output emit_cmd_type             cmd,
   output logic [(CHANNELS*FRAMES*TILES > 1 ? $clog2(CHANNELS*FRAMES*TILES) : 1)-1:0]
                                    cmd_base,
   output logic                     bm_we,
   output logic [(CHANNELS*FRAMES*TILES > 1 ? $clog2(CHANNELS*FRAMES*TILES) : 1)-1:0]
                                    bm_waddr,
   output logic [BMP_W-1:0]         bm_wdata
);

   localparam int CH_AW   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int STEP_W  = STEPS > 1 ? $clog2(STEPS) : 1;
   localparam int FR_W    = FRAMES > 1 ? $clog2(FRAMES) : 1;
   localparam int SEQ_D   = CHANNELS * STEPS;
   localparam int SEQ_AW  = SEQ_D > 1 ? $clog2(SEQ_D) : 1;
   localparam int BM_D    = CHANNELS * FRAMES * TILES;
   localparam int BM_AW   = BM_D > 1 ? $clog2(BM_D) : 1;
   localparam int NMAX    = TILES < 16 ? TILES : 16;
   localparam int CST_W   = TIMER_W + STEP_W;
   localparam int DESC_W  = CNT_W + SLOT_W + CNT_W;
   localparam int SENT_W  = DUR_W + FRM_W;

   function automatic logic [FR_W-1:0] frame_wrap(input logic [FRM_W-1:0] f);
      logic [4:0] v;
      v = 5'(f);
      for (int k = 0; k < 8; k++) begin
         if (v >= 5'(FRAMES)) begin
            v = v - 5'(FRAMES);
         end
      end
      return FR_W'(v);
   endfunction

   seq_state_type      state_ff, state_in;
   logic [CH_AW-1:0]   ch_ff, ch_in;
   logic [STEP_W-1:0]  next_ff, next_in;
   logic [CHANNELS-1:0] cvld_ff, cvld_in;
   logic               crvld_ff, crvld_in;

   // request fields
   func_type           func;
   logic [CHAN_W-1:0]  f_chan;
   logic [SIDX_W-1:0]  f_sidx;
   logic [DUR_W-1:0]   f_dur;
   logic [FRM_W-1:0]   f_frm;
   logic [TIDX_W-1:0]  f_tidx;
   logic [BMP_W-1:0]   f_bmp;
   logic [CNT_W-1:0]   f_scnt;
   logic [SLOT_W-1:0]  f_first;
   logic [CNT_W-1:0]   f_tcnt;
   logic               accept, ch_ok;
   logic [CH_AW-1:0]   req_ch;

   // RAM ports
   logic               cst_we, cst_re, desc_we, desc_re, seq_we, seq_re;
   logic [CH_AW-1:0]   cst_waddr;
   logic [CST_W-1:0]   cst_wdata, cst_rdata;
   logic [DESC_W-1:0]  desc_wdata, desc_rdata;
   logic [SEQ_AW-1:0]  seq_waddr, seq_raddr;
   logic [SENT_W-1:0]  seq_wdata, seq_rdata;

   // tick datapath
   logic [TIMER_W-1:0] timer, timer_dec;
   logic [STEP_W-1:0]  step;
   logic [CNT_W-1:0]   d_scnt, d_tcnt, n_tiles;
   logic [SLOT_W-1:0]  d_first;
   logic [6:0]         cnt_sat, nxt7;
   logic [FR_W-1:0]    frame_m;

   assign func    = func_type'(req_tuser);
   assign f_chan  = req_tdata[CHAN_LSB  +: CHAN_W];
   assign f_sidx  = req_tdata[SIDX_LSB  +: SIDX_W];
   assign f_dur   = req_tdata[DUR_LSB   +: DUR_W];
   assign f_frm   = req_tdata[FRM_LSB   +: FRM_W];
   assign f_tidx  = req_tdata[TIDX_LSB  +: TIDX_W];
   assign f_bmp   = req_tdata[BMP_LSB   +: BMP_W];
   assign f_scnt  = req_tdata[SCNT_LSB  +: CNT_W];
   assign f_first = req_tdata[FIRST_LSB +: SLOT_W];
   assign f_tcnt  = req_tdata[TCNT_LSB  +: CNT_W];

   assign req_ch  = CH_AW'(f_chan);
   assign ch_ok   = (int'(f_chan) < CHANNELS);
   assign accept  = req_tvalid && req_tready;

   assign {d_scnt, d_first, d_tcnt} = desc_rdata;
   // a channel never written back reads as timer and step zero
   assign step  = crvld_ff ? cst_rdata[STEP_W-1:0] : '0;
   assign timer = crvld_ff ? cst_rdata[CST_W-1 -: TIMER_W] : '0;

   ttas_ram #(.WIDTH(CST_W), .DEPTH(CHANNELS)) u_chan_ram (
      .clock (clock),
      .we    (cst_we),
      .waddr (cst_waddr),
      .wdata (cst_wdata),
      .re    (cst_re),
      .raddr (req_ch),
      .rdata (cst_rdata)
   );

   ttas_ram #(.WIDTH(DESC_W), .DEPTH(CHANNELS)) u_desc_ram (
      .clock (clock),
      .we    (desc_we),
      .waddr (req_ch),
      .wdata (desc_wdata),
      .re    (desc_re),
      .raddr (req_ch),
      .rdata (desc_rdata)
   );

   ttas_ram #(.WIDTH(SENT_W), .DEPTH(SEQ_D)) u_step_ram (
      .clock (clock),
      .we    (seq_we),
      .waddr (seq_waddr),
      .wdata (seq_wdata),
      .re    (seq_re),
      .raddr (seq_raddr),
      .rdata (seq_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cvld_ff  <= '0;
         crvld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cvld_ff  <= cvld_in;
         crvld_ff <= crvld_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      next_ff <= next_in;
   end

   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      next_in    = next_ff;
      cvld_in    = cvld_ff;
      crvld_in   = crvld_ff;
      req_tready = 1'b0;

      cst_we     = 1'b0;
      cst_re     = 1'b0;
      cst_waddr  = ch_ff;
      cst_wdata  = '0;
      desc_we    = 1'b0;
      desc_re    = 1'b0;
      desc_wdata = {f_scnt, f_first, f_tcnt};
      seq_we     = 1'b0;
      seq_re     = 1'b0;
      seq_waddr  = SEQ_AW'(req_ch) * SEQ_AW'(STEPS) + SEQ_AW'(f_sidx);
      seq_wdata  = {f_dur, f_frm};
      bm_we      = 1'b0;
      bm_waddr   = (BM_AW'(req_ch) * BM_AW'(FRAMES) + BM_AW'(f_frm)) * BM_AW'(TILES)
                   + BM_AW'(f_tidx);
      bm_wdata   = f_bmp;

      timer_dec  = timer - TIMER_W'(1);
      cnt_sat    = (7'(d_scnt) > 7'(STEPS)) ? 7'(STEPS) : 7'(d_scnt);
      nxt7       = 7'(step) + 7'd1;
      if (nxt7 >= cnt_sat) begin
         nxt7 = '0;
      end
      seq_raddr  = SEQ_AW'(ch_ff) * SEQ_AW'(STEPS) + SEQ_AW'(nxt7);

      frame_m    = frame_wrap(seq_rdata[FRM_W-1:0]);
      n_tiles    = (d_tcnt > CNT_W'(NMAX)) ? CNT_W'(NMAX) : d_tcnt;
      cmd.start      = 1'b0;
      cmd.first_tile = d_first;
      cmd.count      = n_tiles;
      cmd_base   = (BM_AW'(ch_ff) * BM_AW'(FRAMES) + BM_AW'(frame_m)) * BM_AW'(TILES);

      unique case (state_ff)
         ST_IDLE: begin
            // hold off while a change is still being walked
            req_tready = !emit_busy;
            if (accept && ch_ok) begin
               unique case (func)
                  FN_TICK: begin
                     cst_re   = 1'b1;
                     desc_re  = 1'b1;
                     ch_in    = req_ch;
                     crvld_in = cvld_ff[req_ch];
                     state_in = ST_TICK;
                  end
                  FN_DESC: begin
                     desc_we = 1'b1;
                  end
                  FN_STEP: begin
                     seq_we = (int'(f_sidx) < STEPS);
                  end
                  FN_BITMAP: begin
                     bm_we = (int'(f_tidx) < TILES) && (int'(f_frm) < FRAMES);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (!timer_dec[TIMER_W-1]) begin
               // timer still running: store it and drop the tick
               cst_we          = 1'b1;
               cst_wdata       = {timer_dec, step};
               cvld_in[ch_ff]  = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               seq_re   = 1'b1;
               next_in  = STEP_W'(nxt7);
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            // reload timer from the new step and hand the change over
            cst_we         = 1'b1;
            cst_wdata      = {TIMER_W'(seq_rdata[SENT_W-1 -: DUR_W]), next_ff};
            cvld_in[ch_ff] = 1'b1;
            cmd.start      = (n_tiles != '0);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/timed_tile_animation_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_tile_animation_sequencer_unit
// Timed tile animation sequencer: table loads and per-channel ticks in,
// (tile slot, bitmap number) pairs out.
//
// Usage:
//   req_* carries one item per handshake; req_tuser selects tick, descriptor
//   write, sequence step write or bitmap write. Load items give no output.
//   A tick goes from ST_TICK back to ST_IDLE when the timer is still running
//   and on through ST_STEP when it expires; an expiring tick then walks
//   tile_count pairs, at most 16 and at most TILES, out of the bitmap RAM at
//   one pair per cycle while rsp_tready allows, the last pair with rsp_tlast
//   set; the single read port of the bitmap RAM sets that pace.
//   The block takes one item at a time; req_tready stays low while a change
//   is being read out. rsp_tvalid holds with its pair until rsp_tready;
//   a stalled receiver stops the bitmap reads without losing a pair.
//   Reset clears all timers and step positions to zero; no clearing pass is
//   run and the descriptor, step and bitmap tables must be written before
//   a tick reads them.
// ----------------------------------------------------------------------------
module timed_tile_animation_sequencer_unit
   import ttas_pkg::*;
#(
   parameter int CHANNELS = 8,
   parameter int STEPS    = 16,
   parameter int FRAMES   = 8,
   parameter int TILES    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // channel, step_index, duration, frame_number, tile_index, bitmap_value,
   // step_count, first_tile, tile_count, one zero pad bit
   input  logic [REQ_W-1:0]  req_tdata,
   // func
   input  logic [FUNC_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tile_slot, bitmap_number
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tlast
);

   localparam int BM_D  = CHANNELS * FRAMES * TILES;
   localparam int BM_AW = BM_D > 1 ? $clog2(BM_D) : 1;

   emit_cmd_type     cmd;
   logic [BM_AW-1:0] cmd_base;
   logic             bm_we;
   logic [BM_AW-1:0] bm_waddr;
   logic [BMP_W-1:0] bm_wdata;
   logic             emit_busy;

   ttas_seq #(
      .CHANNELS (CHANNELS),
      .STEPS    (STEPS),
      .FRAMES   (FRAMES),
      .TILES    (TILES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .emit_busy  (emit_busy),
      .cmd        (cmd),
      .cmd_base   (cmd_base),
      .bm_we      (bm_we),
      .bm_waddr   (bm_waddr),
      .bm_wdata   (bm_wdata)
   );

   ttas_emit #(
      .BM_DEPTH (BM_D)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_base   (cmd_base),
      .bm_we      (bm_we),
      .bm_waddr   (bm_waddr),
      .bm_wdata   (bm_wdata),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
